// ----- rtl/caldc_pkg.sv -----
// Shared types, command codes and calendar helper functions for the
// calendar date counter. No dependencies.
`default_nettype none

package caldc_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned CENT_W  = 7;   // century part of the year, 0 to 99
	localparam int unsigned YOFS_W  = 7;   // year within the century, 0 to 99

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FWD   = 2'd1,
		CMD_BACK  = 2'd2,
		CMD_QUERY = 2'd3
	} command_t;

	typedef struct packed {
		command_t             command;
		logic [YEAR_W-1:0]    load_year;
		logic [MONTH_W-1:0]   load_month;
		logic [DAY_W-1:0]     load_day;
	} cmd_word_t;

	typedef struct packed {
		logic [YEAR_W-1:0]    year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day_of_month;
		logic [2:0]           weekday;
		logic                 leap_flag;
		logic                 load_error;
	} res_word_t;

	// The year is held split as century and year within the century.
	typedef struct packed {
		logic [CENT_W-1:0]    cent;
		logic [YOFS_W-1:0]    yofs;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
	} date_t;

	// Gregorian leap rule on the split year.
	function automatic logic is_leap(input logic [CENT_W:0] cent, input logic [YOFS_W-1:0] yofs);
		logic r;
		if (yofs == '0) begin
			r = (cent[1:0] == 2'd0);
		end else begin
			r = (yofs[1:0] == 2'd0);
		end
		return r;
	endfunction

	// Month length; zero for a month code that names no month.
	function automatic logic [DAY_W-1:0] last_day(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2: r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Month term of Zeller's congruence, floor(13 * (mm + 1) / 5), where
	// January and February count as months 13 and 14 of the year before.
	function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
		logic [5:0] r;
		case (m)
			4'd1:  r = 6'd36;
			4'd2:  r = 6'd39;
			4'd3:  r = 6'd10;
			4'd4:  r = 6'd13;
			4'd5:  r = 6'd15;
			4'd6:  r = 6'd18;
			4'd7:  r = 6'd20;
			4'd8:  r = 6'd23;
			4'd9:  r = 6'd26;
			4'd10: r = 6'd28;
			4'd11: r = 6'd31;
			4'd12: r = 6'd33;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	// Remainder by 7 of a 10-bit value: since 8 is 1 modulo 7, the octal
	// digits are folded together until a single correction remains.
	function automatic logic [2:0] mod7(input logic [9:0] s);
		logic [7:0] a;
		logic [4:0] b;
		logic [3:0] c;
		a = 8'(s[9:3]) + 8'(s[2:0]);
		b = 5'(a[7:3]) + 5'(a[2:0]);
		c = 4'(b[4:3]) + 4'(b[2:0]);
		return (c >= 4'd7) ? 3'(c - 4'd7) : c[2:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/calendar_date_counter_core.sv -----
// Gregorian calendar date counter with a Zeller weekday; uses caldc_pkg.
// A command word passes through stage 1, the stage 2 date state and the
// output register before its result word shows on res_valid.
// Throughput: one word per cycle while res_stall is low; the date state feeds
// back through update logic; the weekday is worked out one stage after it.
// Reset: the date returns to 0001/01/01 and the pipeline empties.
`default_nettype none

module calendar_date_counter_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_stall,
	input  caldc_pkg::cmd_word_t  cmd_word,
	output logic                  res_valid,
	input  wire                   res_stall,
	output caldc_pkg::res_word_t  res_word
);
	import caldc_pkg::*;

	// Stage 1 holds the accepted command word with the load year already
	// split into century and year within the century. The split divides by
	// 100 through a multiply by 5243 / 2^19, exact for every 14-bit year.
	logic                  valid_s1;
	command_t              cmd_s1;
	logic [7:0]            lcent_s1;
	logic [YOFS_W-1:0]     lyofs_s1;
	logic [MONTH_W-1:0]    lmonth_s1;
	logic [DAY_W-1:0]      lday_s1;

	// Stage 2 is the date state itself plus the load error of the word
	// that last updated it. The state always equals the date of that word.
	logic                  valid_s2;
	logic                  err_s2;
	date_t                 date_q;

	// The output register.
	logic                  valid_out_q;
	res_word_t             res_q;

	logic                  adv_out;
	logic                  adv_s2;
	logic                  take_s1;

	logic [26:0]           in_prod;
	logic [7:0]            in_cent;
	logic [YOFS_W-1:0]     in_yofs;

	date_t                 date_d;
	logic                  err_d;
	logic                  cur_leap;
	logic [DAY_W-1:0]      cur_last;
	logic                  load_leap;
	logic [DAY_W-1:0]      load_last;
	logic                  load_ok;
	logic [MONTH_W-1:0]    prev_month;

	logic [CENT_W-1:0]     z_cent;
	logic [YOFS_W-1:0]     z_yofs;
	logic [9:0]            z_sum;
	res_word_t             res_d;

	// A stage moves forward when the stage after it is empty or moving too,
	// so a finished result can wait while new words keep flowing in.
	assign adv_out   = valid_s2 && (!valid_out_q || !res_stall);
	assign adv_s2    = valid_s1 && (!valid_s2 || adv_out);
	assign cmd_stall = valid_s1 && !adv_s2;
	assign take_s1   = cmd_valid && !cmd_stall;

	assign in_prod = 27'(cmd_word.load_year) * 27'd5243;
	assign in_cent = in_prod[26:19];
	assign in_yofs = 7'(cmd_word.load_year - 14'(in_cent) * 14'd100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1 || adv_s2) begin
			valid_s1 <= take_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			cmd_s1    <= cmd_word.command;
			lcent_s1  <= in_cent;
			lyofs_s1  <= in_yofs;
			lmonth_s1 <= cmd_word.load_month;
			lday_s1   <= cmd_word.load_day;
		end
	end

	// Date update. The state is always a legal date, so the end of a month
	// is reached exactly when the day equals the month length. Stepping back
	// only lands in February without a change of year, so the current leap
	// flag gives the length of the month that is entered.
	always_comb begin
		cur_leap   = is_leap({1'b0, date_q.cent}, date_q.yofs);
		cur_last   = last_day(date_q.month, cur_leap);
		load_leap  = is_leap(lcent_s1, lyofs_s1);
		load_last  = last_day(lmonth_s1, load_leap);
		load_ok    = (lcent_s1 <= 8'd99) && !(lcent_s1 == 8'd0 && lyofs_s1 == 7'd0) &&
			(lmonth_s1 inside {[4'd1:4'd12]}) && (lday_s1 != 5'd0) && (lday_s1 <= load_last);
		prev_month = (date_q.month <= 4'd1) ? 4'd12 : 4'(date_q.month - 4'd1);
		date_d     = date_q;
		err_d      = 1'b0;
		case (cmd_s1)
			CMD_LOAD: begin
				if (load_ok) begin
					date_d.cent  = lcent_s1[CENT_W-1:0];
					date_d.yofs  = lyofs_s1;
					date_d.month = lmonth_s1;
					date_d.day   = lday_s1;
				end else begin
					err_d = 1'b1;
				end
			end
			CMD_FWD: begin
				if (date_q.day >= cur_last) begin
					date_d.day = 5'd1;
					if (date_q.month >= 4'd12) begin
						date_d.month = 4'd1;
						if (date_q.yofs == 7'd99) begin
							if (date_q.cent == 7'd99) begin
								// Forward past the last day wraps to year 1.
								date_d.cent = 7'd0;
								date_d.yofs = 7'd1;
							end else begin
								date_d.cent = 7'(date_q.cent + 7'd1);
								date_d.yofs = 7'd0;
							end
						end else begin
							date_d.yofs = 7'(date_q.yofs + 7'd1);
						end
					end else begin
						date_d.month = 4'(date_q.month + 4'd1);
					end
				end else begin
					date_d.day = 5'(date_q.day + 5'd1);
				end
			end
			CMD_BACK: begin
				if (date_q.day <= 5'd1) begin
					date_d.month = prev_month;
					date_d.day   = last_day(prev_month, cur_leap);
					if (date_q.month <= 4'd1) begin
						if (date_q.cent == 7'd0 && date_q.yofs == 7'd1) begin
							// Back past the first day wraps to year 9999.
							date_d.cent = 7'd99;
							date_d.yofs = 7'd99;
						end else if (date_q.yofs == 7'd0) begin
							date_d.cent = 7'(date_q.cent - 7'd1);
							date_d.yofs = 7'd99;
						end else begin
							date_d.yofs = 7'(date_q.yofs - 7'd1);
						end
					end
				end else begin
					date_d.day = 5'(date_q.day - 5'd1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			err_s2   <= 1'b0;
			date_q   <= '{cent: 7'd0, yofs: 7'd1, month: 4'd1, day: 5'd1};
		end else begin
			if (adv_s2 || adv_out) begin
				valid_s2 <= adv_s2;
			end
			if (adv_s2) begin
				err_s2 <= err_d;
				date_q <= date_d;
			end
		end
	end

	// Weekday by Zeller's congruence, shifted so that 0 is Monday. January
	// and February belong to the year before; a year within the century of
	// zero in those months borrows from the century, which is then at least 1.
	always_comb begin
		if (date_q.month <= 4'd2) begin
			if (date_q.yofs == 7'd0) begin
				z_cent = 7'(date_q.cent - 7'd1);
				z_yofs = 7'd99;
			end else begin
				z_cent = date_q.cent;
				z_yofs = 7'(date_q.yofs - 7'd1);
			end
		end else begin
			z_cent = date_q.cent;
			z_yofs = date_q.yofs;
		end
		z_sum = 10'(date_q.day) + 10'(zeller_month(date_q.month)) + 10'(z_yofs) +
			10'(z_yofs >> 2) + 10'(z_cent >> 2) + 10'(z_cent) * 10'd5 + 10'd5;

		res_d.year         = 14'(date_q.cent) * 14'd100 + 14'(date_q.yofs);
		res_d.month        = date_q.month;
		res_d.day_of_month = date_q.day;
		res_d.weekday      = mod7(z_sum);
		res_d.leap_flag    = is_leap({1'b0, date_q.cent}, date_q.yofs);
		res_d.load_error   = err_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out_q <= 1'b0;
		end else if (adv_out || (valid_out_q && !res_stall)) begin
			valid_out_q <= adv_out;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_out_q;
	assign res_word  = res_q;

	// A full pipeline behind a stalled result must push back on the input.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_out_q && res_stall) |-> cmd_stall)
		else $error("full pipeline did not stall the command side");

	// A query leaves the date as it was.
	a_query_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && cmd_s1 == CMD_QUERY) |=> (date_q == $past(date_q)))
		else $error("query changed the date");

	// Only a load can raise the load error.
	a_err_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && cmd_s1 != CMD_LOAD) |=> !err_s2)
		else $error("load error raised by a non-load command");

	// A forward step inside a month only advances the day.
	a_fwd_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && cmd_s1 == CMD_FWD && date_q.day < cur_last) |=>
		(date_q.day == 5'($past(date_q.day) + 5'd1)) && (date_q.month == $past(date_q.month)))
		else $error("forward step inside a month went wrong");

	// A result word is built only from a stage that held a word.
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_out_q) |-> $past(valid_s2))
		else $error("result word appeared without a source");

endmodule

`default_nettype wire

// ----- verif/tb_calendar_date_counter_core.sv -----
// Self-checking testbench for calendar_date_counter_core: date stepping, loads and weekday.
// Depends on rtl/caldc_pkg.sv for the word types and command codes, and on the core itself.
`timescale 1ns / 1ps

module tb_calendar_date_counter_core;

	import caldc_pkg::*;

	localparam int YEAR_LAST    = 9999;
	localparam int RANDOM_WORDS = 650;
	// After this many result words the result side holds off for a long
	// stretch, so that the pipeline fills and the core stalls its command side.
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;

	// Date tracker: keeps its own copy of the calendar date, works out the
	// result word that each accepted command word must produce, and checks
	// the result words in order against those expectations.
	class date_tracker;
		logic [YEAR_W-1:0]  cur_year;
		logic [MONTH_W-1:0] cur_month;
		logic [DAY_W-1:0]   cur_day;
		res_word_t          expected_words[$];
		int                 error_count;
		int                 result_index;

		function new();
			cur_year = YEAR_W'(1);
			cur_month = MONTH_W'(1);
			cur_day = DAY_W'(1);
			error_count = 0;
			result_index = 0;
		endfunction

		static function bit leap_year(int y);
			return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
		endfunction

		// Zero for a month number that names no month.
		static function int month_length(int y, int m);
			int len;
			case (m)
				2: len = leap_year(y) ? 29 : 28;
				4, 6, 9, 11: len = 30;
				1, 3, 5, 7, 8, 10, 12: len = 31;
				default: len = 0;
			endcase
			return len;
		endfunction

		// Zeller's congruence, shifted so that 0 is Monday. January and
		// February count as months 13 and 14 of the year before.
		static function int zeller_weekday(int y, int m, int d);
			int yy;
			int mm;
			int k;
			int j;
			yy = y;
			mm = m;
			if (mm <= 2) begin
				yy = yy - 1;
				mm = mm + 12;
			end
			k = yy % 100;
			j = yy / 100;
			return (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j + 5) % 7;
		endfunction

		function void note_command(cmd_word_t w);
			int y;
			int m;
			int d;
			int len;
			res_word_t r;
			y = int'(cur_year);
			m = int'(cur_month);
			d = int'(cur_day);
			r.load_error = 1'b0;
			case (w.command)
				CMD_LOAD: begin
					len = month_length(int'(w.load_year), int'(w.load_month));
					if (int'(w.load_year) >= 1 && int'(w.load_year) <= YEAR_LAST &&
					    int'(w.load_day) >= 1 && int'(w.load_day) <= len) begin
						y = int'(w.load_year);
						m = int'(w.load_month);
						d = int'(w.load_day);
					end else begin
						r.load_error = 1'b1;
					end
				end
				CMD_FWD: begin
					if (d >= month_length(y, m)) begin
						d = 1;
						if (m >= 12) begin
							m = 1;
							y = (y >= YEAR_LAST) ? 1 : y + 1;
						end else begin
							m = m + 1;
						end
					end else begin
						d = d + 1;
					end
				end
				CMD_BACK: begin
					if (d <= 1) begin
						if (m <= 1) begin
							m = 12;
							y = (y <= 1) ? YEAR_LAST : y - 1;
						end else begin
							m = m - 1;
						end
						d = month_length(y, m);
					end else begin
						d = d - 1;
					end
				end
				default: begin
				end
			endcase
			cur_year = YEAR_W'(y);
			cur_month = MONTH_W'(m);
			cur_day = DAY_W'(d);
			r.year = cur_year;
			r.month = cur_month;
			r.day_of_month = cur_day;
			r.weekday = 3'(zeller_weekday(y, m, d));
			r.leap_flag = leap_year(y);
			expected_words.push_back(r);
		endfunction

		task report_mismatch(string what, int got_v, int want_v);
			$display("mismatch at result word %0d: %s got %0d, expected %0d",
			         result_index, what, got_v, want_v);
			error_count++;
		endtask

		task check_result(res_word_t got);
			res_word_t want;
			if (expected_words.size() == 0) begin
				report_mismatch("result word with none pending, year", int'(got.year), 0);
				result_index++;
				return;
			end
			want = expected_words.pop_front();
			if (got.year !== want.year)
				report_mismatch("year", int'(got.year), int'(want.year));
			if (got.month !== want.month)
				report_mismatch("month", int'(got.month), int'(want.month));
			if (got.day_of_month !== want.day_of_month)
				report_mismatch("day_of_month", int'(got.day_of_month), int'(want.day_of_month));
			if (got.weekday !== want.weekday)
				report_mismatch("weekday", int'(got.weekday), int'(want.weekday));
			if (got.leap_flag !== want.leap_flag)
				report_mismatch("leap_flag", int'(got.leap_flag), int'(want.leap_flag));
			if (got.load_error !== want.load_error)
				report_mismatch("load_error", int'(got.load_error), int'(want.load_error));
			result_index++;
		endtask

		function int pending_count();
			return expected_words.size();
		endfunction
	endclass

	// Every input of the core holds a known value from time zero.
	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd_word = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res_word;

	date_tracker tracker;
	int          sent_count = 0;

	calendar_date_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every fourth block of 64 words runs with no idle cycles at all, so that
	// back-to-back traffic is seen on both sides as well as ragged traffic.
	function automatic int draw_wait(int index);
		if ((index / 64) % 4 == 3)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic cmd_word_t load_word(int y, int m, int d);
		cmd_word_t w;
		w.command = CMD_LOAD;
		w.load_year = YEAR_W'(y);
		w.load_month = MONTH_W'(m);
		w.load_day = DAY_W'(d);
		return w;
	endfunction

	// Commands other than a load carry random load fields, which the core
	// must ignore.
	function automatic cmd_word_t step_word(command_t c);
		cmd_word_t w;
		w.command = c;
		w.load_year = YEAR_W'($urandom);
		w.load_month = MONTH_W'($urandom);
		w.load_day = DAY_W'($urandom);
		return w;
	endfunction

	// Random traffic is mostly steps in both directions, with half the loads
	// landing near the end of a month so that month and year rollovers happen often.
	// Some loads are pure noise and exercise the refusal path.
	function automatic cmd_word_t random_word();
		int pick;
		int y;
		int m;
		int len;
		int d;
		cmd_word_t w;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 15))
				0: y = 1;
				1: y = YEAR_LAST;
				2: y = 1900;
				3: y = 2000;
				4: y = 2100;
				5: y = 1600;
				default: y = $urandom_range(1, YEAR_LAST);
			endcase
			m = $urandom_range(1, 12);
			len = date_tracker::month_length(y, m);
			if ($urandom_range(0, 1) == 1)
				d = len - $urandom_range(0, 2);
			else
				d = $urandom_range(1, len);
			w = load_word(y, m, d);
		end else if (pick < 17) begin
			w = step_word(CMD_LOAD);
		end else if (pick < 55) begin
			w = step_word(CMD_FWD);
		end else if (pick < 90) begin
			w = step_word(CMD_BACK);
		end else begin
			w = step_word(CMD_QUERY);
		end
		return w;
	endfunction

	// Offers one command word, starting and ending at a falling edge. A drawn
	// number of idle cycles comes first; valid then stays high until the core
	// takes the word at a rising edge with cmd_stall low.
	task automatic send_word(cmd_word_t w);
		int gap;
		gap = draw_wait(sent_count);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		tracker.note_command(w);
		sent_count++;
		@(negedge clk);
	endtask

	// Result side: before each result word it stalls for a drawn number of
	// cycles, then takes the word. Once, it holds off for a long stretch while
	// the command side keeps offering words.
	initial begin : result_side
		int hold;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = draw_wait(taken);
			if (taken == HOLD_AT)
				hold = HOLD_CYCLES;
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			res_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!res_valid);
			tracker.check_result(res_word);
			taken++;
			@(negedge clk);
		end
	end

	// Watchdog. The slowest correct run is about 700 words plus the long hold;
	// a run that hangs well beyond that is stopped and reported as errors.
	initial begin : watchdog
		#2000000;
		$display("tb_calendar_date_counter_core: errors");
		$finish;
	end

	initial begin : stimulus
		tracker = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: the reset date, wrapping in both directions at the
		// ends of the year range, leap and non-leap century Februaries, every
		// kind of refused load including all-ones fields, and year rollover.
		send_word(step_word(CMD_QUERY));
		send_word(step_word(CMD_BACK));
		send_word(step_word(CMD_FWD));
		send_word(load_word(YEAR_LAST, 12, 31));
		send_word(step_word(CMD_FWD));
		send_word(load_word(2000, 2, 28));
		send_word(step_word(CMD_FWD));
		send_word(step_word(CMD_FWD));
		send_word(step_word(CMD_BACK));
		send_word(load_word(1900, 2, 28));
		send_word(step_word(CMD_FWD));
		send_word(load_word(2023, 2, 29));
		send_word(load_word(2024, 2, 29));
		send_word(load_word(0, 1, 1));
		send_word(load_word(16383, 15, 31));
		send_word(load_word(10000, 6, 15));
		send_word(load_word(2024, 0, 10));
		send_word(load_word(2024, 13, 10));
		send_word(load_word(2024, 4, 31));
		send_word(load_word(2024, 4, 0));
		send_word(load_word(2024, 1, 31));
		send_word(step_word(CMD_FWD));
		send_word(load_word(2024, 12, 31));
		send_word(step_word(CMD_FWD));
		send_word(step_word(CMD_BACK));

		for (int i = 0; i < RANDOM_WORDS; i++)
			send_word(random_word());
		cmd_valid <= 1'b0;

		// Drain: wait for every expected result word, then a few more cycles
		// so that a stray extra result word would still be caught.
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.error_count == 0)
			$display("tb_calendar_date_counter_core: clean");
		else
			$display("tb_calendar_date_counter_core: errors");
		$finish;
	end

endmodule
